@@ rtl/mhtq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhtq_pkg: shared types and codes of the min-heap timer queue
// Opcodes, result kinds, the heap entry layout, the controller states and
// the wrap-safe deadline compare.
// ----------------------------------------------------------------------------
package mhtq_pkg;

   localparam int OPCODE_W = 3;
   localparam int TID_W    = 6;
   localparam int TIME_W   = 32;
   localparam int TMO_W    = 31;
   localparam int KIND_W   = 3;
   localparam int REQ_DW   = 72;
   localparam int RSP_DW   = 40;

   localparam logic [OPCODE_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FIRE      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ADJUST    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_NEXT_TICK = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP       = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd5;

   localparam logic [KIND_W-1:0] KIND_DONE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEXT_DUE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd6;

   typedef struct packed {
      logic [TID_W-1:0]  id;
      logic [TIME_W-1:0] dl;
   } heap_entry_type;

   localparam int HEAP_W = TID_W + TIME_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_RD,
      ST_NT_RD,
      ST_NT_CHK,
      ST_RM_START,
      ST_RM_LAST,
      ST_SD_L,
      ST_SD_R,
      ST_SD_CMP2,
      ST_SD_DEC,
      ST_SU,
      ST_SU_DEC,
      ST_FIN,
      ST_EMIT
   } state_type;

   // True when deadline a lies strictly before deadline b, modulo 2^32.
   function automatic logic dl_before(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return d[TIME_W-1];
   endfunction

endpackage

@@ rtl/mhtq_ram.sv @@
// ----------------------------------------------------------------------------
// mhtq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mhtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/min_heap_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// min_heap_timer_queue_core: timer queue on a binary min-heap of deadlines
// Add, fire, adjust, next-tick, pop and clear on up to HEAP_DEPTH timers.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the req channel: opcode in tuser,
// current time, timer id and timeout in tdata. Deadlines live in a heap RAM
// (id and absolute deadline per slot) and a second RAM maps each id to its
// heap slot; present bits and the entry count are flip-flops, so reset and
// clear take effect at once with no clearing pass. A sift moves the displaced
// entry in registers and writes it back once it settles. The cost of an item
// is set by the single read port of the heap RAM: a sift-up step reads the
// parent and compares, a sift-down step reads the left and, if present, the
// right child and compares. Next-tick gives an expired result and a removal
// for each expired timer, then its final result; rsp stalls delay results.
// Results leave through an output register, so the next item is accepted
// while the final result of the previous one still waits on rsp.
module min_heap_timer_queue_core #(
   parameter int HEAP_DEPTH = 32,
   parameter int ID_COUNT   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] now_ms, [37:32] timer_id, [68:38] timeout_ms, [71:69] zero
   input  logic [mhtq_pkg::REQ_DW-1:0]     req_tdata,
   // [2:0] opcode
   input  logic [mhtq_pkg::OPCODE_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] timer_id_res, [36:6] remaining_ms, [39:37] zero
   output logic [mhtq_pkg::RSP_DW-1:0]     rsp_tdata,
   // [2:0] kind
   output logic [mhtq_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast
);
   import mhtq_pkg::*;

   localparam int SLOT_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int CW     = CNT_W + 1;
   localparam int IDX_W  = $clog2(ID_COUNT);
   localparam int EXT_W  = (IDX_W > TID_W) ? IDX_W : TID_W;

   function automatic logic [IDX_W-1:0] id_idx(input logic [TID_W-1:0] id);
      logic [EXT_W-1:0] e;
      e = EXT_W'(id);
      return e[IDX_W-1:0];
   endfunction

   // Request fields.
   logic [TIME_W-1:0] req_now;
   logic [TID_W-1:0]  req_id;
   logic [TMO_W-1:0]  req_tmo;
   assign req_now = req_tdata[31:0];
   assign req_id  = req_tdata[37:32];
   assign req_tmo = req_tdata[68:38];

   // Control and datapath registers.
   state_type            state_ff, state_in;
   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]    dl_ff, dl_in;
   heap_entry_type       cur_ff, cur_in;
   heap_entry_type       ch_ff, ch_in;
   logic [SLOT_W-1:0]    chi_ff, chi_in;
   logic [SLOT_W-1:0]    i_ff, i_in;
   logic [SLOT_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]     lim_ff, lim_in;
   logic [TID_W-1:0]     rm_id_ff, rm_id_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_COUNT-1:0]  present_ff, present_in;
   logic [KIND_W-1:0]    res_kind_ff, res_kind_in;
   logic [TID_W-1:0]     res_id_ff, res_id_in;
   logic [TMO_W-1:0]     res_rem_ff, res_rem_in;
   logic                 res_last_ff, res_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [TID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [TMO_W-1:0]     rsp_rem_ff, rsp_rem_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                 heap_we;
   logic [SLOT_W-1:0]    heap_waddr, heap_raddr;
   heap_entry_type       heap_wdata, heap_rdata;
   logic                 slot_we;
   logic [IDX_W-1:0]     slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]    slot_wdata, slot_rdata;

   mhtq_ram #(.WIDTH(HEAP_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   mhtq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_COUNT)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // The slot table is read with the incoming id, so the slot of the id is
   // ready in the dispatch cycle.
   assign slot_raddr = id_idx(req_id);

   logic              id_in_range;
   logic              id_known;
   logic [CW-1:0]     left_c;
   logic [CW-1:0]     right_c;
   logic [SLOT_W-1:0] parent_p;
   logic [CNT_W-1:0]  count_m1;
   logic [TIME_W-1:0] nt_diff;
   logic              post_tick;

   assign id_in_range = 32'(id_ff) < ID_COUNT;
   assign id_known    = id_in_range && present_ff[id_idx(id_ff)];
   assign left_c      = CW'({i_ff, 1'b1});
   assign right_c     = left_c + CW'(1);
   assign parent_p    = (i_ff - SLOT_W'(1)) >> 1;
   assign count_m1    = count_ff - CNT_W'(1);
   assign nt_diff     = heap_rdata.dl - now_ff;
   assign post_tick   = (op_ff == OP_NEXT_TICK);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      id_in        = id_ff;
      dl_in        = dl_ff;
      cur_in       = cur_ff;
      ch_in        = ch_ff;
      chi_in       = chi_ff;
      i_in         = i_ff;
      start_in     = start_ff;
      lim_in       = lim_ff;
      rm_id_in     = rm_id_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      res_kind_in  = res_kind_ff;
      res_id_in    = res_id_ff;
      res_rem_in   = res_rem_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_last_in  = rsp_last_ff;
      heap_we      = 1'b0;
      heap_waddr   = i_ff;
      heap_wdata   = cur_ff;
      heap_raddr   = '0;
      slot_we      = 1'b0;
      slot_waddr   = id_idx(cur_ff.id);
      slot_wdata   = i_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               now_in   = req_now;
               id_in    = req_id;
               dl_in    = req_now + TIME_W'(req_tmo);
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_kind_in = KIND_DONE;
            res_id_in   = '0;
            res_rem_in  = '0;
            res_last_in = 1'b1;
            state_in    = ST_EMIT;
            case (op_ff)
               OP_ADD, OP_ADJUST: begin
                  if (!id_known) begin
                     if (op_ff == OP_ADJUST || !id_in_range) begin
                        res_kind_in = KIND_UNKNOWN;
                     end else if (count_ff == CNT_W'(HEAP_DEPTH)) begin
                        res_kind_in = KIND_FULL;
                     end else begin
                        // New timer goes to the end of the heap and moves up.
                        present_in[id_idx(id_ff)] = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        cur_in   = '{id: id_ff, dl: dl_ff};
                        i_in     = count_ff[SLOT_W-1:0];
                        state_in = ST_SU;
                     end
                  end else begin
                     cur_in   = '{id: id_ff, dl: dl_ff};
                     i_in     = slot_rdata;
                     start_in = slot_rdata;
                     lim_in   = count_ff;
                     state_in = ST_SD_L;
                  end
               end
               OP_FIRE: begin
                  if (!id_known) begin
                     res_kind_in = KIND_UNKNOWN;
                  end else begin
                     res_kind_in = KIND_FIRED;
                     res_id_in   = id_ff;
                     rm_id_in    = id_ff;
                     i_in        = slot_rdata;
                     state_in    = ST_RM_START;
                  end
               end
               OP_NEXT_TICK: begin
                  state_in = ST_NT_RD;
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     res_kind_in = KIND_EMPTY;
                  end else begin
                     heap_raddr = '0;
                     state_in   = ST_POP_RD;
                  end
               end
               OP_CLEAR: begin
                  present_in = '0;
                  count_in   = '0;
               end
               default: begin
               end
            endcase
         end
         ST_POP_RD: begin
            rm_id_in = heap_rdata.id;
            i_in     = '0;
            state_in = ST_RM_START;
         end
         ST_NT_RD: begin
            if (count_ff == '0) begin
               res_kind_in = KIND_EMPTY;
               res_id_in   = '0;
               res_rem_in  = '0;
               res_last_in = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               heap_raddr = '0;
               state_in   = ST_NT_CHK;
            end
         end
         ST_NT_CHK: begin
            state_in = ST_EMIT;
            if (nt_diff == '0 || nt_diff[TIME_W-1]) begin
               res_kind_in = KIND_EXPIRED;
               res_id_in   = heap_rdata.id;
               res_rem_in  = '0;
               res_last_in = 1'b0;
               rm_id_in    = heap_rdata.id;
               i_in        = '0;
            end else begin
               res_kind_in = KIND_NEXT_DUE;
               res_id_in   = '0;
               res_rem_in  = nt_diff[TMO_W-1:0];
               res_last_in = 1'b1;
            end
         end
         ST_RM_START: begin
            // The last entry fills the hole and is re-sifted from there.
            present_in[id_idx(rm_id_ff)] = 1'b0;
            count_in = count_m1;
            lim_in   = count_m1;
            if (CNT_W'(i_ff) < count_m1) begin
               heap_raddr = count_m1[SLOT_W-1:0];
               state_in   = ST_RM_LAST;
            end else begin
               state_in = post_tick ? ST_NT_RD : ST_EMIT;
            end
         end
         ST_RM_LAST: begin
            cur_in   = heap_rdata;
            start_in = i_ff;
            state_in = ST_SD_L;
         end
         ST_SD_L: begin
            if (left_c < CW'(lim_ff)) begin
               heap_raddr = left_c[SLOT_W-1:0];
               state_in   = ST_SD_R;
            end else begin
               state_in = (i_ff != start_ff) ? ST_FIN : ST_SU;
            end
         end
         ST_SD_R: begin
            ch_in  = heap_rdata;
            chi_in = left_c[SLOT_W-1:0];
            if (right_c < CW'(lim_ff)) begin
               heap_raddr = right_c[SLOT_W-1:0];
               state_in   = ST_SD_CMP2;
            end else begin
               state_in = ST_SD_DEC;
            end
         end
         ST_SD_CMP2: begin
            if (dl_before(heap_rdata.dl, ch_ff.dl)) begin
               ch_in  = heap_rdata;
               chi_in = right_c[SLOT_W-1:0];
            end
            state_in = ST_SD_DEC;
         end
         ST_SD_DEC: begin
            if (dl_before(cur_ff.dl, ch_ff.dl)) begin
               state_in = (i_ff != start_ff) ? ST_FIN : ST_SU;
            end else begin
               heap_we    = 1'b1;
               heap_wdata = ch_ff;
               slot_we    = 1'b1;
               slot_waddr = id_idx(ch_ff.id);
               i_in       = chi_ff;
               state_in   = ST_SD_L;
            end
         end
         ST_SU: begin
            if (i_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               heap_raddr = parent_p;
               state_in   = ST_SU_DEC;
            end
         end
         ST_SU_DEC: begin
            if (dl_before(heap_rdata.dl, cur_ff.dl)) begin
               state_in = ST_FIN;
            end else begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               slot_we    = 1'b1;
               slot_waddr = id_idx(heap_rdata.id);
               i_in       = parent_p;
               state_in   = ST_SU;
            end
         end
         ST_FIN: begin
            heap_we  = 1'b1;
            slot_we  = 1'b1;
            state_in = post_tick ? ST_NT_RD : ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_id_in    = res_id_ff;
               rsp_rem_in   = res_rem_ff;
               rsp_last_in  = res_last_ff;
               state_in     = res_last_ff ? ST_IDLE : ST_RM_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      id_ff       <= id_in;
      dl_ff       <= dl_in;
      cur_ff      <= cur_in;
      ch_ff       <= ch_in;
      chi_ff      <= chi_in;
      i_ff        <= i_in;
      start_ff    <= start_in;
      lim_ff      <= lim_in;
      rm_id_ff    <= rm_id_in;
      res_kind_ff <= res_kind_in;
      res_id_ff   <= res_id_in;
      res_rem_ff  <= res_rem_in;
      res_last_ff <= res_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_rem_ff, rsp_id_ff};

endmodule

@@ rtl/mhtq_checker.sv @@
// ----------------------------------------------------------------------------
// mhtq_checker: port-level checks of the timer queue
// Watches the req and rsp channels and is bound to min_heap_timer_queue_core.
// ----------------------------------------------------------------------------
module mhtq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mhtq_pkg::RSP_DW-1:0]   rsp_tdata,
   input logic [mhtq_pkg::KIND_W-1:0]   rsp_tuser,
   input logic                          rsp_tlast
);
   import mhtq_pkg::*;

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // The queue works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted twice in a row");

   // Only an expired-id result is followed by more results of its item.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_EXPIRED)))
      else $error("tlast does not match result kind");

   // The id field is zero unless the kind reports an id.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_EXPIRED && rsp_tuser != KIND_FIRED
         |-> rsp_tdata[5:0] == 6'd0)
      else $error("id set on a result without an id");

endmodule

bind min_heap_timer_queue_core mhtq_checker u_mhtq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the min-heap timer queue core
// Drives timer operations on the req stream, predicts every result item with
// a behavioral heap model and compares the rsp stream in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import mhtq_pkg::*;

   localparam int DEPTH    = 32;
   localparam int IDS      = 64;
   localparam int WATCHDOG = 20000;

   // One expected result item.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TID_W-1:0]  tid;
      logic [TMO_W-1:0]  remain;
      logic              lst;
   } timer_result_type;

   // One row of the directed table; chk_kind set means the kind is typed in.
   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [TIME_W-1:0]   now;
      logic [TID_W-1:0]    tid;
      logic [TMO_W-1:0]    tmo;
      bit                  chk_kind;
      logic [KIND_W-1:0]   kind;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic rsp_tlast;

   min_heap_timer_queue_core #(.HEAP_DEPTH(DEPTH), .ID_COUNT(IDS)) uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: a heap of ids and absolute deadlines plus the slot map.
   logic [TID_W-1:0]  hp_id[DEPTH];
   logic [TIME_W-1:0] hp_dl[DEPTH];
   int                slot_of[IDS];
   bit                present[IDS];
   int                count;

   timer_result_type pending_results[$];
   int  mismatches = 0;
   int  idle_pct_tx = 0;
   int  idle_pct_rx = 0;
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;
   int  issued = 0;

   function automatic bit earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return d[TIME_W-1];
   endfunction

   function automatic void swap_entries(int i, int j);
      logic [TID_W-1:0]  t;
      logic [TIME_W-1:0] d;
      t = hp_id[i]; d = hp_dl[i];
      hp_id[i] = hp_id[j]; hp_dl[i] = hp_dl[j];
      hp_id[j] = t; hp_dl[j] = d;
      slot_of[hp_id[i]] = i;
      slot_of[hp_id[j]] = j;
   endfunction

   function automatic void bubble_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (earlier(hp_dl[p], hp_dl[i])) break;
         swap_entries(i, p);
         i = p;
      end
   endfunction

   // Sinks slot i within the first n entries; returns 1 when it moved.
   function automatic bit sink(int i, int n);
      int s, c;
      s = i;
      c = 2 * i + 1;
      while (c < n) begin
         if (c + 1 < n && earlier(hp_dl[c+1], hp_dl[c])) c++;
         if (earlier(hp_dl[i], hp_dl[c])) break;
         swap_entries(i, c);
         i = c;
         c = 2 * i + 1;
      end
      return i > s;
   endfunction

   function automatic void reheap(int i, int n);
      if (!sink(i, n)) bubble_up(i);
   endfunction

   function automatic void drop_slot(int i);
      int n;
      n = count - 1;
      if (i < n) begin
         swap_entries(i, n);
         reheap(i, n);
      end
      present[hp_id[n]] = 1'b0;
      count = n;
   endfunction

   function automatic void push_result(logic [KIND_W-1:0] k, logic [TID_W-1:0] t,
                                       logic [TMO_W-1:0] r);
      timer_result_type e;
      e = '{k, t, r, 1'b0};
      pending_results.insert(pending_results.size(), e);
   endfunction

   // Applies one timer operation to the predictor and queues its results.
   function automatic void predict_timer_op(logic [OPCODE_W-1:0] op,
                                            logic [TIME_W-1:0] now,
                                            logic [TID_W-1:0] tid,
                                            logic [TMO_W-1:0] tmo);
      logic [TIME_W-1:0] dl, diff;
      int s;
      dl = now + {1'b0, tmo};
      case (op)
         OP_ADD: begin
            if (present[tid]) begin
               hp_dl[slot_of[tid]] = dl;
               reheap(slot_of[tid], count);
               push_result(KIND_DONE, '0, '0);
            end else if (count >= DEPTH) begin
               push_result(KIND_FULL, '0, '0);
            end else begin
               s = count;
               hp_id[s] = tid; hp_dl[s] = dl;
               slot_of[tid] = s; present[tid] = 1'b1;
               count++;
               bubble_up(s);
               push_result(KIND_DONE, '0, '0);
            end
         end
         OP_FIRE: begin
            if (!present[tid]) push_result(KIND_UNKNOWN, '0, '0);
            else begin
               push_result(KIND_FIRED, tid, '0);
               drop_slot(slot_of[tid]);
            end
         end
         OP_ADJUST: begin
            if (!present[tid]) push_result(KIND_UNKNOWN, '0, '0);
            else begin
               hp_dl[slot_of[tid]] = dl;
               reheap(slot_of[tid], count);
               push_result(KIND_DONE, '0, '0);
            end
         end
         OP_NEXT_TICK: begin
            while (count > 0) begin
               diff = hp_dl[0] - now;
               if (diff != 0 && !diff[TIME_W-1]) break;
               push_result(KIND_EXPIRED, hp_id[0], '0);
               drop_slot(0);
            end
            if (count > 0) begin
               diff = hp_dl[0] - now;
               push_result(KIND_NEXT_DUE, '0, diff[TMO_W-1:0]);
            end else push_result(KIND_EMPTY, '0, '0);
         end
         OP_POP: begin
            if (count == 0) push_result(KIND_EMPTY, '0, '0);
            else begin
               drop_slot(0);
               push_result(KIND_DONE, '0, '0);
            end
         end
         OP_CLEAR: begin
            foreach (present[i]) present[i] = 1'b0;
            count = 0;
            push_result(KIND_DONE, '0, '0);
         end
         default: push_result(KIND_DONE, '0, '0);
      endcase
      pending_results[pending_results.size() - 1].lst = 1'b1;
   endfunction

   // Offers one item, honoring the sender idle rate, and waits for acceptance.
   // The predictor runs at the accepting edge so the expectation is queued
   // before the first result can appear.
   task automatic send_timer_op(logic [OPCODE_W-1:0] op, logic [TIME_W-1:0] now,
                                logic [TID_W-1:0] tid, logic [TMO_W-1:0] tmo);
      while ($urandom_range(99) < idle_pct_tx) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, tmo, tid, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer_op(op, now, tid, tmo);
      issued++;
   endtask

   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected result item has arrived.
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= idle_pct_rx);
   end

   // Compares each accepted result item with the oldest expectation.
   always @(posedge clock) begin
      timer_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result kind=%0d id=%0d rem=%0d last=%0b",
                        rsp_tuser, rsp_tdata[5:0], rsp_tdata[36:6], rsp_tlast);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tuser !== exp_r.kind || rsp_tdata[5:0] !== exp_r.tid ||
                rsp_tdata[36:6] !== exp_r.remain || rsp_tdata[39:37] !== 3'b000 ||
                rsp_tlast !== exp_r.lst) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: expected kind=%0d id=%0d rem=%0d last=%0b, ",
                            "got kind=%0d id=%0d rem=%0d last=%0b"},
                           exp_r.kind, exp_r.tid, exp_r.remain, exp_r.lst,
                           rsp_tuser, rsp_tdata[5:0], rsp_tdata[36:6], rsp_tlast);
            end
         end
      end
   end

   // Watchdog: the long hold-off keeps the result side quiet on purpose, so
   // only cycles with no handshake and no intentional hold count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_rsp || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Random item generator biased toward ids 0 to 39 and near-term deadlines.
   task automatic send_random_op(logic [TIME_W-1:0] base);
      logic [OPCODE_W-1:0] op;
      logic [TID_W-1:0]    tid;
      logic [TMO_W-1:0]    tmo;
      logic [TIME_W-1:0]   now;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < 40) op = OP_ADD;
      else if (pick < 52) op = OP_FIRE;
      else if (pick < 64) op = OP_ADJUST;
      else if (pick < 84) op = OP_NEXT_TICK;
      else if (pick < 92) op = OP_POP;
      else if (pick < 95) op = OP_CLEAR;
      else op = OPCODE_W'($urandom_range(7));
      tid = $urandom_range(11) == 0 ? TID_W'($urandom) : TID_W'($urandom_range(39));
      tmo = $urandom_range(9) == 0 ? TMO_W'($urandom) : TMO_W'($urandom_range(400));
      now = $urandom_range(19) == 0 ? $urandom : base + $urandom_range(300);
      send_timer_op(op, now, tid, tmo);
   endtask

   stim_row_type directed[$];

   initial begin
      logic [TIME_W-1:0] base;
      count = 0;
      foreach (present[i]) present[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: kinds typed in where obvious, everything predicted.
      directed = '{
         '{OP_NEXT_TICK, 32'd0,          6'd0,  31'd0,          1, KIND_EMPTY},
         '{OP_POP,       32'd0,          6'd0,  31'd0,          1, KIND_EMPTY},
         '{OP_FIRE,      32'd0,          6'd63, 31'd0,          1, KIND_UNKNOWN},
         '{OP_ADJUST,    32'd0,          6'd5,  31'd9,          1, KIND_UNKNOWN},
         '{OP_ADD,       32'hFFFF_FFF0,  6'd63, 31'h7FFF_FFFF,  1, KIND_DONE},
         '{OP_ADD,       32'hFFFF_FFF0,  6'd0,  31'd32,         1, KIND_DONE},
         '{OP_ADD,       32'hFFFF_FFF0,  6'd1,  31'd32,         1, KIND_DONE},
         '{OP_ADD,       32'hFFFF_FFF0,  6'd2,  31'd0,          1, KIND_DONE},
         '{OP_ADD,       32'hFFFF_FFF0,  6'd1,  31'd5,          0, KIND_DONE},
         '{OP_ADJUST,    32'd0,          6'd63, 31'd1,          0, KIND_DONE},
         '{OP_NEXT_TICK, 32'hFFFF_FFF0,  6'd0,  31'd0,          0, KIND_DONE},
         '{OP_NEXT_TICK, 32'd20,         6'd0,  31'd0,          0, KIND_DONE},
         '{OP_FIRE,      32'd0,          6'd63, 31'd0,          1, KIND_UNKNOWN},
         '{3'd6,         32'd0,          6'd0,  31'd0,          1, KIND_DONE},
         '{3'd7,         32'hFFFF_FFFF,  6'd63, 31'h7FFF_FFFF,  1, KIND_DONE},
         '{OP_ADD,       32'd100,        6'd7,  31'd50,         1, KIND_DONE},
         '{OP_POP,       32'd0,          6'd0,  31'd0,          1, KIND_DONE},
         '{OP_CLEAR,     32'd0,          6'd0,  31'd0,          1, KIND_DONE},
         '{OP_NEXT_TICK, 32'd0,          6'd0,  31'd0,          1, KIND_EMPTY}
      };
      foreach (directed[i]) begin
         send_timer_op(directed[i].op, directed[i].now, directed[i].tid,
                       directed[i].tmo);
         if (directed[i].chk_kind && pending_results[$].kind !== directed[i].kind) begin
            mismatches++;
            $display("ERROR: directed row %0d predicts kind %0d, table says %0d",
                     i, pending_results[$].kind, directed[i].kind);
         end
      end
      release_req();
      drain();

      // Fill past capacity with equal deadlines, then tick them all out at once
      // so one item yields the largest burst of results. The receiver is held
      // off while items keep coming so the block backs up.
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      for (int k = 0; k < DEPTH + 2; k++)
         send_timer_op(OP_ADD, 32'd1000, TID_W'(k), 31'd10);
      send_timer_op(OP_NEXT_TICK, 32'd1010, '0, '0);
      release_req();
      wait (!hold_rsp);
      drain();

      // Random part in idling phases; each phase ends with a full drain.
      base = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct_tx = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 20) : 0;
         idle_pct_rx = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 20) : 0;
         for (int k = 0; k < 25; k++) begin
            send_random_op(base);
            base += $urandom_range(40);
         end
         release_req();
         drain();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
